/* hdl/tcc_pkg.sv */
`timescale 1ns / 1ps

// Shared types and constants of the text console cursor buffer.
package tcc_pkg;

	// Operation selected by the input beat.
	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_SET   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_e_t;

	// Control characters that put character treats specially.
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Tab stops lie on multiples of this step (a power of two).
	localparam int TAB_STEP = 8;

	// Attribute after reset: light gray on black.
	localparam logic [7:0] ATTR_RESET = 8'h07;

	// Register index of the text attribute (paddr bit 2).
	localparam logic REG_TEXT_ATTR = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // latch the input beat
		logic exec;       // apply the operation, write at most one cell, update the cursor
		logic copy_step;  // scroll: move one cell up by one row
		logic fill_step;  // write one blank cell
		logic load_out;   // load the result register
	} tcc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scroll;  // the operation moved below the last row
		logic need_fill;    // the operation clears the screen
		logic copy_last;    // the current copy step is the last one
		logic fill_last;    // the current fill step reaches the last cell
		logic out_free;     // the result register can take a new result
	} tcc_stat_t;

endpackage

/* hdl/text_console_cursor_buffer_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  Signals                          Content
// s_*       in   s_tvalid s_tready s_tuser s_tdata  one console operation per beat
// m_*       out  m_tvalid m_tready m_tdata          cursor, read cell, scroll flag
// apb       in   psel penable pwrite paddr pwdata   text attribute register (0x0)
//
// An operation goes from input beat to result through latch, execute and result.
// Scrolling moves the rows up one cell per cycle through the single write port and
// then blanks the last row; clear blanks every cell through that port as well.
// After reset a clearing pass writes every cell with s_tready low; register writes
// are taken meanwhile.
// s_tready is high only between operations; a result waits in its output register
// while the next beat is taken, and a stalled result holds the controller in place.
module text_console_cursor_buffer_top #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	input  logic [23:0] s_tdata,   // [7:0] char_code, [15:8] col_in, [23:16] row_in
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] cursor_col, [11:7] cursor_row, [19:12] cell_char, [27:20] cell_attr,
	// [28] scrolled, [31:29] zero
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tcc_pkg::tcc_cmd_t  cmd;
	tcc_pkg::tcc_stat_t stat;
	logic [7:0]         text_attr_q;

	// Attribute register behind the APB port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= tcc_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == tcc_pkg::REG_TEXT_ATTR)) begin
			text_attr_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tcc_pkg::REG_TEXT_ATTR) ? {24'b0, text_attr_q} : '0;

	tcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	tcc_dp #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.text_attr (text_attr_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

/* hdl/tcc_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/tcc_ctrl.sv */
`timescale 1ns / 1ps

// Controller: sequences the clearing pass, the operations, scroll and result.
module tcc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output tcc_pkg::tcc_cmd_t   cmd,
	input  tcc_pkg::tcc_stat_t  stat
);

	typedef enum logic [5:0] {
		ST_INIT = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_EXEC = 6'b000100,
		ST_COPY = 6'b001000,
		ST_FILL = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Next state and command decode.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_scroll) begin
					state_nxt = ST_COPY;
				end else if (stat.need_fill) begin
					state_nxt = ST_FILL;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (stat.copy_last) begin
					state_nxt = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

/* hdl/tcc_dp.sv */
`timescale 1ns / 1ps

// Datapath: item registers, cursor, screen store, sweep counter and result register.
module tcc_dp #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcc_pkg::tcc_cmd_t   cmd,
	output tcc_pkg::tcc_stat_t  stat,
	input  logic [1:0]          s_tuser,
	input  logic [23:0]         s_tdata,
	input  logic [7:0]          text_attr,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata
);

	localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(SCREEN_COLS);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);

	// Latched input beat.
	tcc_pkg::cmd_e_t op_q;
	logic [7:0]      char_q;
	logic [7:0]      col_in_q;
	logic [7:0]      row_in_q;

	// Cursor and sweep state.
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [7:0]        fill_attr_q;
	logic [ADDR_W-1:0] idx_q;

	// Delayed write stage shared by copy and fill.
	logic              s1_valid_q;
	logic [ADDR_W-1:0] s1_addr_q;
	logic              s1_copy_q;

	// Result register.
	logic       m_valid_q;
	logic [6:0] out_col_q;
	logic [4:0] out_row_q;
	logic [7:0] out_char_q;
	logic [7:0] out_attr_q;
	logic       out_scr_q;
	logic       scrolled_q;

	// Screen store port signals.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	// Operation decode.
	logic              in_range;
	logic [ADDR_W-1:0] item_addr;
	logic [COL_W:0]    col_ext;
	logic [COL_W:0]    col_inc;
	logic [COL_W:0]    tab_col;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic              line_feed;
	logic              need_scroll;
	logic              need_fill;
	logic              wr_exec;
	logic [COL_W-1:0]  wr_col;
	logic [7:0]        wr_char;
	logic [ADDR_W-1:0] exec_addr;
	logic [COL_W+6:0]  col_pad;
	logic [ROW_W+4:0]  row_pad;

	// Position check and address of the addressed cell.
	assign in_range  = (col_in_q < 8'(SCREEN_COLS)) && (row_in_q < 8'(SCREEN_ROWS));
	assign item_addr = ADDR_W'(row_in_q[ROW_W-1:0]) * ADDR_W'(SCREEN_COLS)
		+ ADDR_W'(col_in_q[COL_W-1:0]);

	// Column arithmetic for ordinary characters and tab.
	assign col_ext = {1'b0, cur_col_q};
	assign col_inc = col_ext + (COL_W+1)'(1);
	assign tab_col = (col_ext + (COL_W+1)'(tcc_pkg::TAB_STEP))
		& ~(COL_W+1)'(tcc_pkg::TAB_STEP - 1);

	// Next cursor, cell write and follow-up work of the latched operation.
	always_comb begin
		nxt_col     = cur_col_q;
		nxt_row     = cur_row_q;
		line_feed   = 1'b0;
		need_scroll = 1'b0;
		need_fill   = 1'b0;
		wr_exec     = 1'b0;
		wr_col      = cur_col_q;
		wr_char     = char_q;
		unique case (op_q)
			tcc_pkg::CMD_PUT: begin
				unique case (char_q)
					tcc_pkg::CH_LF: begin
						line_feed = 1'b1;
					end
					tcc_pkg::CH_CR: begin
						nxt_col = '0;
					end
					tcc_pkg::CH_TAB: begin
						if (tab_col >= (COL_W+1)'(SCREEN_COLS)) begin
							line_feed = 1'b1;
						end else begin
							nxt_col = tab_col[COL_W-1:0];
						end
					end
					tcc_pkg::CH_BS: begin
						if (cur_col_q != '0) begin
							nxt_col = cur_col_q - 1'b1;
							wr_exec = 1'b1;
							wr_col  = cur_col_q - 1'b1;
							wr_char = tcc_pkg::CH_SPACE;
						end
					end
					default: begin
						wr_exec = 1'b1;
						if (col_inc >= (COL_W+1)'(SCREEN_COLS)) begin
							line_feed = 1'b1;
						end else begin
							nxt_col = col_inc[COL_W-1:0];
						end
					end
				endcase
			end
			tcc_pkg::CMD_CLEAR: begin
				nxt_col   = '0;
				nxt_row   = '0;
				need_fill = 1'b1;
			end
			tcc_pkg::CMD_SET: begin
				if (in_range) begin
					nxt_col = col_in_q[COL_W-1:0];
					nxt_row = row_in_q[ROW_W-1:0];
				end
			end
			tcc_pkg::CMD_READ: begin
			end
			default: begin
			end
		endcase
		// A line feed at the bottom row scrolls instead of moving down.
		if (line_feed) begin
			nxt_col = '0;
			if (cur_row_q == ROW_W'(SCREEN_ROWS - 1)) begin
				need_scroll = 1'b1;
			end else begin
				nxt_row = cur_row_q + 1'b1;
			end
		end
	end

	assign exec_addr = ADDR_W'(cur_row_q) * ADDR_W'(SCREEN_COLS) + ADDR_W'(wr_col);

	// Store ports: the delayed stage writes during sweeps, the operation otherwise.
	assign ram_we    = s1_valid_q || (cmd.exec && wr_exec);
	assign ram_waddr = s1_valid_q ? s1_addr_q : exec_addr;
	assign ram_wdata = s1_valid_q ? (s1_copy_q ? ram_rdata : {fill_attr_q, tcc_pkg::CH_SPACE})
		: {text_attr, wr_char};
	assign ram_raddr = cmd.copy_step ? (idx_q + ADDR_W'(SCREEN_COLS)) : item_addr;

	tcc_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Status toward the controller.
	assign stat.need_scroll = need_scroll;
	assign stat.need_fill   = need_fill;
	assign stat.copy_last   = (idx_q == ADDR_W'(CELLS - SCREEN_COLS - 1));
	assign stat.fill_last   = (idx_q == ADDR_W'(CELLS - 1));
	assign stat.out_free    = !m_valid_q || m_tready;

	// Input beat capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= tcc_pkg::cmd_e_t'(s_tuser);
			char_q   <= s_tdata[7:0];
			col_in_q <= s_tdata[15:8];
			row_in_q <= s_tdata[23:16];
		end
		if (cmd.exec) begin
			scrolled_q <= need_scroll;
		end
	end

	// Cursor, fill attribute, sweep counter and delayed write stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			fill_attr_q <= tcc_pkg::ATTR_RESET;
			idx_q       <= '0;
			s1_valid_q  <= 1'b0;
			s1_addr_q   <= '0;
			s1_copy_q   <= 1'b0;
		end else begin
			s1_valid_q <= cmd.copy_step || cmd.fill_step;
			s1_addr_q  <= idx_q;
			s1_copy_q  <= cmd.copy_step;
			if (cmd.exec) begin
				cur_col_q   <= nxt_col;
				cur_row_q   <= nxt_row;
				fill_attr_q <= text_attr;
				idx_q       <= '0;
			end else if (cmd.copy_step || cmd.fill_step) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign col_pad = {7'b0, cur_col_q};
	assign row_pad = {5'b0, cur_row_q};

	// Result payload; the cell fields carry data only for an in-range read.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_col_q <= col_pad[6:0];
			out_row_q <= row_pad[4:0];
			out_scr_q <= scrolled_q;
			if ((op_q == tcc_pkg::CMD_READ) && in_range) begin
				out_char_q <= ram_rdata[7:0];
				out_attr_q <= ram_rdata[15:8];
			end else begin
				out_char_q <= '0;
				out_attr_q <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b0, out_scr_q, out_attr_q, out_char_q, out_row_q, out_col_q};

endmodule

/* tb/tb_text_console_cursor_buffer_top.sv */
`timescale 1ns / 1ps

module tb_text_console_cursor_buffer_top;
	import tcc_pkg::*;

	localparam int N_COLS = 80;
	localparam int N_ROWS = 25;
	localparam int N_CELLS = N_COLS * N_ROWS;
	localparam logic [2:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};
	// Scrolls and clears each walk the whole screen, so the random part caps them.
	localparam int SLOW_BUDGET = 110;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_OPS = 110;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;   // [1:0] cmd
	logic [23:0] s_tdata;   // [7:0] char_code, [15:8] col_in, [23:16] row_in
	logic        m_tvalid;
	logic        m_tready;
	// [6:0] cursor_col, [11:7] cursor_row, [19:12] cell_char, [27:20] cell_attr,
	// [28] scrolled, [31:29] zero
	logic [31:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// One console operation as it travels on the input channel.
	typedef struct {
		cmd_e_t   cmd;
		bit [7:0] ch;
		bit [7:0] col;
		bit [7:0] row;
	} console_op_t;

	// Cursor and cell that one operation reports.
	typedef struct {
		bit [6:0] col;
		bit [4:0] row;
		bit [7:0] cell_char;
		bit [7:0] cell_attr;
		bit       scrolled;
	} cursor_result_t;

	// Keeps its own copy of the screen and cursor and checks every result beat.
	class console_scoreboard;
		bit [15:0]      cells [N_CELLS];
		int unsigned    col_pos;
		int unsigned    row_pos;
		bit [7:0]       attr;
		cursor_result_t cursor_results_q [$];
		int unsigned    errors;
		int unsigned    slow_ops;

		function new();
			attr = ATTR_RESET;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
			slow_ops = 0;
			blank_screen();
		endfunction

		task report(string what);
			errors++;
			$display("ERROR at %0t ns: %s", $time, what);
		endtask

		function void blank_screen();
			for (int i = 0; i < N_CELLS; i++)
				cells[i] = {attr, CH_SPACE};
		endfunction

		// Moves to the start of the next line; returns 1 when the screen scrolled.
		function bit new_line();
			col_pos = 0;
			row_pos++;
			if (row_pos < N_ROWS)
				return 1'b0;
			for (int i = 0; i + N_COLS < N_CELLS; i++)
				cells[i] = cells[i + N_COLS];
			for (int i = N_CELLS - N_COLS; i < N_CELLS; i++)
				cells[i] = {attr, CH_SPACE};
			row_pos = N_ROWS - 1;
			slow_ops++;
			return 1'b1;
		endfunction

		function bit put_char(bit [7:0] ch);
			case (ch)
				CH_LF: begin
					return new_line();
				end
				CH_CR: begin
					col_pos = 0;
					return 1'b0;
				end
				CH_TAB: begin
					col_pos = (col_pos + TAB_STEP) & ~(TAB_STEP - 1);
					if (col_pos >= N_COLS)
						return new_line();
					return 1'b0;
				end
				CH_BS: begin
					// Backspace stops at the left edge and never climbs a line.
					if (col_pos > 0) begin
						col_pos--;
						cells[row_pos * N_COLS + col_pos] = {attr, CH_SPACE};
					end
					return 1'b0;
				end
				default: begin
					cells[row_pos * N_COLS + col_pos] = {attr, ch};
					col_pos++;
					if (col_pos >= N_COLS)
						return new_line();
					return 1'b0;
				end
			endcase
		endfunction

		// Applies an accepted operation and queues the result it must give.
		function void note_op(console_op_t op);
			cursor_result_t r;
			bit [15:0] cell_word;
			r = '{default: 0};
			case (op.cmd)
				CMD_PUT: begin
					r.scrolled = put_char(op.ch);
				end
				CMD_CLEAR: begin
					blank_screen();
					col_pos = 0;
					row_pos = 0;
					slow_ops++;
				end
				CMD_SET: begin
					if (32'(op.col) < N_COLS && 32'(op.row) < N_ROWS) begin
						col_pos = 32'(op.col);
						row_pos = 32'(op.row);
					end
				end
				default: begin
					if (32'(op.col) < N_COLS && 32'(op.row) < N_ROWS) begin
						cell_word = cells[32'(op.row) * N_COLS + 32'(op.col)];
						r.cell_char = cell_word[7:0];
						r.cell_attr = cell_word[15:8];
					end
				end
			endcase
			r.col = col_pos[6:0];
			r.row = row_pos[4:0];
			cursor_results_q.push_back(r);
		endfunction

		task check_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		endtask

		task check_result(logic [31:0] data);
			cursor_result_t want;
			if (cursor_results_q.size() == 0) begin
				report($sformatf("result beat 0x%08h with nothing outstanding", data));
				return;
			end
			want = cursor_results_q.pop_front();
			check_field("cursor_col", 32'(data[6:0]), 32'(want.col));
			check_field("cursor_row", 32'(data[11:7]), 32'(want.row));
			check_field("cell_char", 32'(data[19:12]), 32'(want.cell_char));
			check_field("cell_attr", 32'(data[27:20]), 32'(want.cell_attr));
			check_field("scrolled", 32'(data[28]), 32'(want.scrolled));
			check_field("padding", 32'(data[31:29]), 0);
		endtask

		function int pending();
			return cursor_results_q.size();
		endfunction
	endclass

	console_scoreboard sb;
	bit no_idle;

	text_console_cursor_buffer_top #(
		.SCREEN_COLS(N_COLS),
		.SCREEN_ROWS(N_ROWS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#30_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic console_op_t make_op(cmd_e_t cmd, int ch, int col, int row);
		console_op_t op;
		op.cmd = cmd;
		op.ch = ch[7:0];
		op.col = col[7:0];
		op.row = row[7:0];
		return op;
	endfunction

	function automatic console_op_t random_op();
		console_op_t op;
		int unsigned pick;
		int unsigned kind;
		op = make_op(CMD_PUT, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			kind = $urandom_range(0, 99);
			if (kind < 6)
				op.ch = CH_LF;
			else if (kind < 10)
				op.ch = CH_CR;
			else if (kind < 16)
				op.ch = CH_TAB;
			else if (kind < 24)
				op.ch = CH_BS;
		end else if (pick < 58) begin
			op.cmd = CMD_CLEAR;
		end else if (pick < 76) begin
			op.cmd = CMD_SET;
			if ($urandom_range(0, 3) != 0) begin
				op.col = 8'($urandom_range(0, N_COLS - 1));
				op.row = 8'($urandom_range(0, N_ROWS - 1));
			end
		end else begin
			op.cmd = CMD_READ;
			// Most reads pick a cell on the screen, half of those on the line being written, where the content changes.
			if ($urandom_range(0, 4) != 0) begin
				op.col = 8'($urandom_range(0, N_COLS - 1));
				op.row = 8'($urandom_range(0, 1) ? sb.row_pos
					: $urandom_range(0, N_ROWS - 1));
			end
		end
		// Once the budget of full-screen walks is spent, steer clear of them.
		if (sb.slow_ops >= SLOW_BUDGET) begin
			if (op.cmd == CMD_CLEAR) begin
				op.cmd = CMD_READ;
			end else if (op.cmd == CMD_PUT && sb.row_pos == N_ROWS - 1) begin
				op.cmd = CMD_SET;
				op.col = 8'($urandom_range(0, N_COLS - 1));
				op.row = 8'($urandom_range(0, N_ROWS - 2));
			end
		end
		return op;
	endfunction

	// Offers one beat on the input channel and returns at the edge that takes it.
	task automatic send_op(console_op_t op);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op.cmd;
		s_tdata <= {op.row, op.col, op.ch};
		do @(posedge clk); while (!s_tready);
		sb.note_op(op);
	endtask

	// Stops sending and waits until every outstanding result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit is_write, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_attr(bit [7:0] want);
		logic [31:0] rdata;
		apb_access(1'b0, ATTR_ADDR, 32'd0, rdata);
		if (rdata !== {24'd0, want})
			sb.report($sformatf("text_attribute reads 0x%0h, expected 0x%0h", rdata, want));
	endtask

	task automatic write_attr(bit [7:0] value);
		logic [31:0] rdata;
		apb_access(1'b1, ATTR_ADDR, {24'd0, value}, rdata);
		sb.attr = value;
		check_attr(value);
	endtask

	// Result side: random stalls, every beat checked against the oldest expectation.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata);
		end
	end

	initial begin
		bit [7:0] phase_attr [5];
		sb = new();
		no_idle = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = CMD_PUT;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its screen after reset before it takes any beat.
		do @(posedge clk); while (!s_tready);
		check_attr(ATTR_RESET);

		// Directed: reset content, field extremes and every control character.
		send_op(make_op(CMD_READ, 0, 0, 0));
		send_op(make_op(CMD_READ, 0, N_COLS - 1, N_ROWS - 1));
		send_op(make_op(CMD_PUT, 8'h41, 0, 0));
		send_op(make_op(CMD_PUT, 8'h00, 0, 0));
		send_op(make_op(CMD_PUT, 8'hFF, 0, 0));
		send_op(make_op(CMD_PUT, CH_BS, 0, 0));
		send_op(make_op(CMD_PUT, CH_CR, 0, 0));
		send_op(make_op(CMD_PUT, CH_BS, 0, 0));
		send_op(make_op(CMD_PUT, CH_TAB, 0, 0));
		send_op(make_op(CMD_PUT, CH_LF, 0, 0));
		// Wrap at the line end, then a tab that runs past it.
		send_op(make_op(CMD_SET, 0, N_COLS - 1, 0));
		send_op(make_op(CMD_PUT, 8'h5A, 0, 0));
		send_op(make_op(CMD_SET, 0, N_COLS - 4, 3));
		send_op(make_op(CMD_PUT, CH_TAB, 0, 0));
		// Positions off the screen are ignored.
		send_op(make_op(CMD_SET, 0, N_COLS, 0));
		send_op(make_op(CMD_SET, 0, 0, N_ROWS));
		send_op(make_op(CMD_SET, 0, 255, 255));
		send_op(make_op(CMD_READ, 0, N_COLS, 0));
		send_op(make_op(CMD_READ, 0, 0, 255));
		// Scrolls by a wrapping character, a line feed and a tab on the last row.
		send_op(make_op(CMD_SET, 0, N_COLS - 1, N_ROWS - 1));
		send_op(make_op(CMD_PUT, 8'h78, 0, 0));
		send_op(make_op(CMD_PUT, CH_LF, 0, 0));
		send_op(make_op(CMD_SET, 0, N_COLS - 5, N_ROWS - 1));
		send_op(make_op(CMD_PUT, CH_TAB, 0, 0));
		send_op(make_op(CMD_READ, 0, N_COLS - 1, N_ROWS - 4));
		send_op(make_op(CMD_PUT, CH_LF, 0, 0));
		send_op(make_op(CMD_CLEAR, 0, 0, 0));
		send_op(make_op(CMD_READ, 0, 3, 2));

		// Random phases, each under its own attribute; one runs without idling.
		phase_attr[0] = 8'h00;
		phase_attr[1] = 8'($urandom_range(1, 254));
		phase_attr[2] = 8'hFF;
		phase_attr[3] = 8'($urandom_range(1, 254));
		phase_attr[4] = 8'($urandom_range(0, 255));
		for (int p = 0; p < 5; p++) begin
			drain();
			write_attr(phase_attr[p]);
			no_idle = (p == 2);
			repeat (PHASE_OPS) send_op(random_op());
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
